// ===== hw/rtl/fesm_pkg.sv =====
// ----------------------------------------------------------------------------
// fesm_pkg: shared types and constants of the file extent stripe map
// payload structs of both channels and request/response structs of the
// serial divider and multiplier
// ----------------------------------------------------------------------------
package fesm_pkg;

    localparam int OFF_W      = 63;
    localparam int CFG_W      = 32;
    localparam int DIV_W      = 64;
    localparam int MP_W       = 33;
    localparam int STEP_W     = $clog2(DIV_W + 1);
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_LSB   = $clog2(PAGE_BYTES);

    typedef struct packed {
        logic [OFF_W-1:0] file_offset;
        logic [OFF_W-1:0] extent_bytes;
    } extent_t;

    typedef struct packed {
        logic [CFG_W-1:0] object_number;
        logic [CFG_W-1:0] in_object_offset;
        logic [OFF_W-1:0] in_object_length;
        logic [OFF_W-1:0] next_offset;
        logic [OFF_W-1:0] remaining_bytes;
        logic             unit_misaligned;
    } map_t;

    // dividend is left aligned: its top steps bits are the operand
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [CFG_W-1:0]  mcand;
        logic [MP_W-1:0]   mplier;
        logic [STEP_W-1:0] steps;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] prod;
    } mul_rsp_t;

endpackage

// ===== hw/rtl/fesm_div.sv =====
// ----------------------------------------------------------------------------
// fesm_div: bit-serial restoring divider
// one quotient bit per cycle, up to 64 bits; a zero divisor gives an all-ones
// quotient and the dividend as remainder
// ----------------------------------------------------------------------------
module fesm_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  fesm_pkg::div_req_t  req,
    output fesm_pkg::div_rsp_t  rsp
);
    import fesm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;

    logic [DIV_W:0]    partial;
    logic [DIV_W:0]    diff;
    logic              fits;

    assign partial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = partial >= {1'b0, dsr_reg};
    assign diff    = partial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        priority if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== hw/rtl/fesm_mul.sv =====
// ----------------------------------------------------------------------------
// fesm_mul: bit-serial shift-add multiplier
// one multiplier bit per cycle, product kept to 64 bits
// ----------------------------------------------------------------------------
module fesm_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  fesm_pkg::mul_req_t  req,
    output fesm_pkg::mul_rsp_t  rsp
);
    import fesm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  acc_reg, acc_next;
    logic [DIV_W-1:0]  mc_reg, mc_next;
    logic [MP_W-1:0]   mp_reg, mp_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        priority if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            acc_next  = '0;
            mc_next   = DIV_W'(req.mcand);
            mp_next   = req.mplier;
        end
        else if (busy_reg)
        begin
            acc_next = mp_reg[0] ? acc_reg + mc_reg : acc_reg;
            mc_next  = {mc_reg[DIV_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[MP_W-1:1]};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== hw/rtl/file_extent_to_object_stripe_map.sv =====
// ----------------------------------------------------------------------------
// file_extent_to_object_stripe_map: maps a file extent onto a striped object
// gives object number, in-object offset and length, next offset and the rest
// ----------------------------------------------------------------------------
// usage
//   extent channel (extent_valid / extent_stall / extent) takes one file
//   extent per transaction; map channel (map_valid / map_stall / map) returns
//   one mapping per extent, in order
//   object size, stripe unit and stripe count sit behind the APB port at
//   byte addresses 0, 4 and 8; write them only while no extent is in flight
//   one extent is worked on at a time: six serial divisions (one quotient bit
//   a cycle) and three serial multiplies (one bit a cycle) share a single
//   divider and a single multiplier; the next extent can be taken in the cycle
//   in which map_valid rises; a zero stripe length or a first piece that
//   reaches the object end skips the last two divisions; a zero-length
//   extent skips the last one
//   extent_stall is high from acceptance until the result enters the output
//   register; a stalled result holds there and the next extent is already
//   taken and worked on, waiting only at its own final step
//   reset loads object size 4 MiB, unit 64 KiB, count 1 and empties the block
// ----------------------------------------------------------------------------
module file_extent_to_object_stripe_map
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               extent_valid,
    output logic               extent_stall,
    input  fesm_pkg::extent_t  extent,
    output logic               map_valid,
    input  logic               map_stall,
    output fesm_pkg::map_t     map,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fesm_pkg::*;

    localparam logic [1:0] REG_OBJECT = 2'd0;
    localparam logic [1:0] REG_UNIT   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PER,
        ST_BLK,
        ST_STR,
        ST_SET,
        ST_BNO,
        ST_SLEN,
        ST_XF,
        ST_NOBJ,
        ST_NLEN,
        ST_NU,
        ST_OX,
        ST_CAP,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic             launched_reg, launched_next;
    logic             out_valid_reg, out_valid_next;
    logic [CFG_W-1:0] obj_reg, obj_next;
    logic [CFG_W-1:0] unit_reg, unit_next;
    logic [CFG_W-1:0] width_reg, width_next;

    logic [OFF_W-1:0] off_reg, off_next;
    logic [OFF_W-1:0] len_reg, len_next;
    logic [CFG_W-1:0] per_reg, per_next;
    logic [CFG_W-1:0] blk_reg, blk_next;
    logic [CFG_W-1:0] x_reg, x_next;
    logic [CFG_W-1:0] stripe_reg, stripe_next;
    logic [CFG_W-1:0] pos_reg, pos_next;
    logic [CFG_W-1:0] set_reg, set_next;
    logic [CFG_W-1:0] bno_reg, bno_next;
    logic [DIV_W-1:0] s_reg, s_next;
    logic [CFG_W-1:0] first_reg, first_next;
    logic [MP_W-1:0]  xf_reg, xf_next;
    logic [MP_W-1:0]  ou_reg, ou_next;
    logic [MP_W-1:0]  nobj_reg, nobj_next;
    logic [MP_W-1:0]  n_reg, n_next;
    logic [MP_W+1:0]  nu_reg, nu_next;
    logic [OFF_W-1:0] ox_reg, ox_next;
    logic [OFF_W-1:0] nxt_reg, nxt_next;
    map_t             map_reg, map_next;

    div_req_t         div_req;
    div_rsp_t         div_rsp;
    mul_req_t         mul_req;
    mul_rsp_t         mul_rsp;

    logic             cfg_write;
    logic             extent_take;
    logic             out_free;
    logic [MP_W-1:0]  num;
    logic [OFF_W-1:0] len_less;

    fesm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fesm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign extent_stall = (state_reg != ST_IDLE);
    assign extent_take  = extent_valid && !extent_stall;
    assign out_free     = !out_valid_reg || !map_stall;
    assign map_valid    = out_valid_reg;
    assign map          = map_reg;
    assign num          = ou_reg - xf_reg;
    assign len_less     = len_reg - OFF_W'(1);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OBJECT: prdata = obj_reg;
            REG_UNIT:   prdata = unit_reg;
            REG_WIDTH:  prdata = width_reg;
            default:    prdata = '0;
        endcase
    end

    // operand selection for the shared serial units
    always_comb
    begin
        div_req = '0;
        mul_req = '0;
        unique case (state_reg)
            ST_PER:
            begin
                div_req.dividend = {obj_reg, 32'd0};
                div_req.divisor  = DIV_W'(unit_reg);
                div_req.steps    = STEP_W'(32);
            end
            ST_BLK:
            begin
                div_req.dividend = {off_reg, 1'b0};
                div_req.divisor  = DIV_W'(unit_reg);
                div_req.steps    = STEP_W'(OFF_W);
            end
            ST_STR:
            begin
                div_req.dividend = {blk_reg, 32'd0};
                div_req.divisor  = DIV_W'(width_reg);
                div_req.steps    = STEP_W'(32);
            end
            ST_SET:
            begin
                div_req.dividend = {stripe_reg, 32'd0};
                div_req.divisor  = DIV_W'(per_reg);
                div_req.steps    = STEP_W'(32);
            end
            ST_NOBJ:
            begin
                div_req.dividend = {num, 31'd0};
                div_req.divisor  = DIV_W'(unit_reg);
                div_req.steps    = STEP_W'(MP_W);
            end
            ST_NLEN:
            begin
                div_req.dividend = {len_less, 1'b0};
                div_req.divisor  = s_reg;
                div_req.steps    = STEP_W'(OFF_W);
            end
            ST_BNO:
            begin
                mul_req.mcand  = width_reg;
                mul_req.mplier = MP_W'(set_reg);
                mul_req.steps  = STEP_W'(32);
            end
            ST_SLEN:
            begin
                mul_req.mcand  = unit_reg;
                mul_req.mplier = MP_W'(width_reg);
                mul_req.steps  = STEP_W'(32);
            end
            ST_NU:
            begin
                mul_req.mcand  = unit_reg;
                mul_req.mplier = n_reg;
                mul_req.steps  = STEP_W'(MP_W);
            end
            default:
            begin
                div_req = '0;
                mul_req = '0;
            end
        endcase
        div_req.start = !launched_reg && (state_reg == ST_PER || state_reg == ST_BLK
                        || state_reg == ST_STR || state_reg == ST_SET
                        || (state_reg == ST_NOBJ && s_reg != '0
                            && xf_reg < MP_W'(obj_reg))
                        || (state_reg == ST_NLEN && len_reg != '0));
        mul_req.start = !launched_reg && (state_reg == ST_BNO || state_reg == ST_SLEN
                        || state_reg == ST_NU);
    end

    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        out_valid_next = out_valid_reg && map_stall;
        obj_next       = obj_reg;
        unit_next      = unit_reg;
        width_next     = width_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        per_next       = per_reg;
        blk_next       = blk_reg;
        x_next         = x_reg;
        stripe_next    = stripe_reg;
        pos_next       = pos_reg;
        set_next       = set_reg;
        bno_next       = bno_reg;
        s_next         = s_reg;
        first_next     = first_reg;
        xf_next        = xf_reg;
        ou_next        = ou_reg;
        nobj_next      = nobj_reg;
        n_next         = n_reg;
        nu_next        = nu_reg;
        ox_next        = ox_reg;
        nxt_next       = nxt_reg;
        map_next       = map_reg;

        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_OBJECT: obj_next   = pwdata;
                REG_UNIT:   unit_next  = pwdata;
                REG_WIDTH:  width_next = pwdata;
                default:    obj_next   = obj_reg;
            endcase
        end

        if (div_req.start || mul_req.start)
        begin
            launched_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (extent_take)
                begin
                    off_next   = extent.file_offset;
                    len_next   = extent.extent_bytes;
                    state_next = ST_PER;
                end
            end
            ST_PER:
            begin
                if (launched_reg && div_rsp.done)
                begin
                    per_next      = div_rsp.quo[CFG_W-1:0];
                    launched_next = 1'b0;
                    state_next    = ST_BLK;
                end
            end
            ST_BLK:
            begin
                if (launched_reg && div_rsp.done)
                begin
                    blk_next      = div_rsp.quo[CFG_W-1:0];
                    x_next        = div_rsp.rem[CFG_W-1:0];
                    launched_next = 1'b0;
                    state_next    = ST_STR;
                end
            end
            ST_STR:
            begin
                if (launched_reg && div_rsp.done)
                begin
                    stripe_next   = div_rsp.quo[CFG_W-1:0];
                    pos_next      = div_rsp.rem[CFG_W-1:0];
                    launched_next = 1'b0;
                    state_next    = ST_SET;
                end
            end
            ST_SET:
            begin
                if (launched_reg && div_rsp.done)
                begin
                    set_next      = div_rsp.quo[CFG_W-1:0];
                    launched_next = 1'b0;
                    state_next    = ST_BNO;
                end
            end
            ST_BNO:
            begin
                if (launched_reg && mul_rsp.done)
                begin
                    bno_next      = mul_rsp.prod[CFG_W-1:0] + pos_reg;
                    launched_next = 1'b0;
                    state_next    = ST_SLEN;
                end
            end
            ST_SLEN:
            begin
                if (launched_reg && mul_rsp.done)
                begin
                    s_next        = mul_rsp.prod;
                    first_next    = (len_reg < OFF_W'(unit_reg)) ? len_reg[CFG_W-1:0]
                                                                 : unit_reg;
                    launched_next = 1'b0;
                    state_next    = ST_XF;
                end
            end
            ST_XF:
            begin
                xf_next    = MP_W'(x_reg) + MP_W'(first_reg);
                ou_next    = MP_W'(obj_reg) + MP_W'(unit_reg) - MP_W'(1);
                state_next = ST_NOBJ;
            end
            ST_NOBJ:
            begin
                // no growth with a zero stripe length or a first piece that reaches the object end
                priority if (!launched_reg && !div_req.start)
                begin
                    n_next     = '0;
                    state_next = ST_NU;
                end
                else if (launched_reg && div_rsp.done)
                begin
                    nobj_next     = div_rsp.quo[MP_W-1:0];
                    launched_next = 1'b0;
                    state_next    = ST_NLEN;
                end
            end
            ST_NLEN:
            begin
                priority if (!launched_reg && !div_req.start)
                begin
                    n_next     = '0;
                    state_next = ST_NU;
                end
                else if (launched_reg && div_rsp.done)
                begin
                    n_next        = (div_rsp.quo < DIV_W'(nobj_reg))
                                    ? div_rsp.quo[MP_W-1:0] : nobj_reg;
                    launched_next = 1'b0;
                    state_next    = ST_NU;
                end
            end
            ST_NU:
            begin
                if (launched_reg && mul_rsp.done)
                begin
                    nu_next       = mul_rsp.prod[MP_W+1:0];
                    launched_next = 1'b0;
                    state_next    = ST_OX;
                end
            end
            ST_OX:
            begin
                ox_next    = OFF_W'(nu_reg) + OFF_W'(first_reg);
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                ox_next    = (ox_reg > len_reg) ? len_reg : ox_reg;
                nxt_next   = off_reg + OFF_W'(first_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    map_next.object_number    = bno_reg;
                    map_next.in_object_offset = x_reg;
                    map_next.in_object_length = ox_reg;
                    map_next.next_offset      = nxt_reg;
                    map_next.remaining_bytes  = len_reg - ox_reg;
                    map_next.unit_misaligned  = (unit_reg[PAGE_LSB-1:0] != '0);
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            obj_reg       <= 32'd4194304;
            unit_reg      <= 32'd65536;
            width_reg     <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            obj_reg       <= obj_next;
            unit_reg      <= unit_next;
            width_reg     <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        len_reg    <= len_next;
        per_reg    <= per_next;
        blk_reg    <= blk_next;
        x_reg      <= x_next;
        stripe_reg <= stripe_next;
        pos_reg    <= pos_next;
        set_reg    <= set_next;
        bno_reg    <= bno_next;
        s_reg      <= s_next;
        first_reg  <= first_next;
        xf_reg     <= xf_next;
        ou_reg     <= ou_next;
        nobj_reg   <= nobj_next;
        n_reg      <= n_next;
        nu_reg     <= nu_next;
        ox_reg     <= ox_next;
        nxt_reg    <= nxt_next;
        map_reg    <= map_next;
    end

`ifndef SYNTHESIS
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        extent_take |=> (state_reg == ST_PER))
        else $error("accepted extent did not start the mapping");

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> map_valid)
        else $error("finished mapping not presented");

    a_len_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (ox_reg <= len_reg))
        else $error("in-object length exceeds extent length");

    a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.done || mul_rsp.done) |-> launched_reg)
        else $error("serial unit finished without a pending operation");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for file_extent_to_object_stripe_map
// drives random and corner-case extents under many register settings and
// compares every mapping against an in-bench model of the stripe layout
// ----------------------------------------------------------------------------
module tb;
    import fesm_pkg::*;

    localparam logic [3:0] ADDR_OBJECT = 4'd0;
    localparam logic [3:0] ADDR_UNIT   = 4'd4;
    localparam logic [3:0] ADDR_COUNT  = 4'd8;
    localparam logic [3:0] ADDR_SPARE  = 4'd12;
    localparam int         IDLE_MAX    = 18;
    localparam int         QUIET_LIMIT = 5000;
    localparam int         DRAIN_WAIT  = 400;
    localparam int         ITEM_GOAL   = 650;
    localparam logic [62:0] MAX63      = {63{1'b1}};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        extent_valid = 1'b0;
    logic        extent_stall;
    extent_t     extent = '0;
    logic        map_valid;
    logic        map_stall = 1'b0;
    map_t        map;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // register copies seen by the layout model
    logic [31:0] cfg_object = 32'd4194304;
    logic [31:0] cfg_unit   = 32'd65536;
    logic [31:0] cfg_count  = 32'd1;

    extent_t extents_todo[$];
    map_t    maps_due[$];
    int      items_queued = 0;
    int      results_seen = 0;
    int      mismatches = 0;
    int      layouts = 0;
    int      misaligned_seen = 0;
    int      zero_len_seen = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      quiet = 0;
    bit      no_idle = 1'b0;

    file_extent_to_object_stripe_map uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .extent_valid (extent_valid),
        .extent_stall (extent_stall),
        .extent       (extent),
        .map_valid    (map_valid),
        .map_stall    (map_stall),
        .map          (map),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    function automatic map_t stripe_map(extent_t e);
        logic [63:0] off, len, u, o, q, x, first, s, n, n_len, n_obj, mapped, prod;
        logic [31:0] sc, per_obj, blk, stripe, pos, set_no;
        map_t m;
        off = {1'b0, e.file_offset};
        len = {1'b0, e.extent_bytes};
        u = {32'b0, cfg_unit};
        o = {32'b0, cfg_object};
        sc = cfg_count;
        // a quotient by zero is all ones, a remainder by zero is the dividend
        per_obj = (cfg_unit == 0) ? '1 : cfg_object / cfg_unit;
        q = (u == 0) ? '1 : off / u;
        blk = q[31:0];
        stripe = (sc == 0) ? '1 : blk / sc;
        pos = (sc == 0) ? blk : blk % sc;
        set_no = (per_obj == 0) ? '1 : stripe / per_obj;
        prod = {32'b0, set_no} * {32'b0, sc} + {32'b0, pos};
        x = (u == 0) ? off : off % u;
        x = {32'b0, x[31:0]};
        first = (len < u) ? len : u;
        s = {32'b0, sc} * u;
        n = 0;
        if (s != 0)
        begin
            n_len = (len == 0) ? 64'd0 : (len - 1) / s;
            n_obj = (x + first >= o) ? 64'd0 : (o - x - first + u - 1) / u;
            n = (n_len < n_obj) ? n_len : n_obj;
        end
        mapped = first + n * u;
        if (mapped > len)
            mapped = len;
        m.object_number = prod[31:0];
        m.in_object_offset = x[31:0];
        m.in_object_length = mapped[62:0];
        q = off + first;
        m.next_offset = q[62:0];
        q = len - mapped;
        m.remaining_bytes = q[62:0];
        m.unit_misaligned = (cfg_unit % PAGE_BYTES) != 0;
        return m;
    endfunction

    function automatic int draw_idle();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic logic [62:0] rand_span();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0] >> $urandom_range(0, 62);
    endfunction

    function automatic extent_t make_extent();
        extent_t e;
        logic [63:0] u, s, v;
        u = {32'b0, cfg_unit};
        s = u * {32'b0, cfg_count};
        v = {1'b0, rand_span()};
        e.file_offset = v[62:0];
        e.extent_bytes = rand_span();
        case ($urandom_range(0, 7))
            0:
            begin
                v = {$urandom, $urandom};
                e.file_offset = v[62:0];
                v = {$urandom, $urandom};
                e.extent_bytes = v[62:0];
            end
            1, 2:
            begin
                if (u != 0)
                    v = v - v % u;
                v = v + $urandom_range(0, 3);
                e.file_offset = v[62:0];
                v = s * $urandom_range(0, 8) + $urandom_range(0, 2) * u
                    + $urandom_range(0, 3);
                e.extent_bytes = v[62:0];
            end
            3, 4:
            begin
                v = $urandom_range(0, 4) * u + $urandom_range(0, 2048);
                e.extent_bytes = v[62:0];
            end
            5:
            begin
                // land near an object boundary
                v = {32'b0, cfg_object} * $urandom_range(0, 8)
                    - $urandom_range(0, 2) * u + $urandom_range(0, 3);
                e.file_offset = v[62:0];
                v = $urandom_range(1, 6) * u;
                e.extent_bytes = v[62:0];
            end
            default:
            begin
            end
        endcase
        if ($urandom_range(0, 15) == 0)
            e.extent_bytes = '0;
        return e;
    endfunction

    task automatic queue_extent(logic [62:0] off, logic [62:0] len);
        extent_t e;
        e.file_offset = off;
        e.extent_bytes = len;
        extents_todo.push_back(e);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_OBJECT: cfg_object = data;
            ADDR_UNIT:   cfg_unit = data;
            ADDR_COUNT:  cfg_count = data;
            default:     ;
        endcase
    endtask

    task automatic apb_check(logic [3:0] addr, logic [31:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            mismatches++;
            $display("%0t ns: register %0d read expected %h got %h",
                     $time, addr, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // all three registers plus, now and then, a write past the register list
    task automatic set_layout(logic [31:0] obj, logic [31:0] unit, logic [31:0] cnt);
        wait_drained();
        repeat (20) @(posedge clk);
        apb_write(ADDR_OBJECT, obj);
        apb_write(ADDR_UNIT, unit);
        apb_write(ADDR_COUNT, cnt);
        if ($urandom_range(0, 2) == 0)
            apb_write(ADDR_SPARE, $urandom);
        apb_check(ADDR_OBJECT, cfg_object);
        apb_check(ADDR_UNIT, cfg_unit);
        apb_check(ADDR_COUNT, cfg_count);
        layouts++;
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h got %h", $time, fname, want, got);
        end
    endtask

    // extent driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extent_valid <= 1'b0;
            extent <= '0;
            send_gap <= 0;
        end
        else if (!extent_valid || !extent_stall)
        begin
            if (extent_valid)
            begin
                maps_due.push_back(stripe_map(extent));
                if (cfg_unit % PAGE_BYTES != 0)
                    misaligned_seen++;
                if (extent.extent_bytes == 0)
                    zero_len_seen++;
            end
            if (send_gap != 0)
            begin
                extent_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (extents_todo.size() != 0)
            begin
                extent <= extents_todo.pop_front();
                extent_valid <= 1'b1;
                send_gap <= draw_idle();
            end
            else
                extent_valid <= 1'b0;
        end
    end

    // mapping monitor
    always @(posedge clk or negedge rst_n)
    begin
        int   hold;
        map_t want;
        if (!rst_n)
        begin
            map_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            hold = stall_left;
            if (map_valid && !map_stall)
            begin
                if (maps_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: mapping expected none got %h", $time, map);
                end
                else
                begin
                    want = maps_due.pop_front();
                    check_field("object_number", 64'(want.object_number),
                                64'(map.object_number));
                    check_field("in_object_offset", 64'(want.in_object_offset),
                                64'(map.in_object_offset));
                    check_field("in_object_length", 64'(want.in_object_length),
                                64'(map.in_object_length));
                    check_field("next_offset", 64'(want.next_offset),
                                64'(map.next_offset));
                    check_field("remaining_bytes", 64'(want.remaining_bytes),
                                64'(map.remaining_bytes));
                    check_field("unit_misaligned", 64'(want.unit_misaligned),
                                64'(map.unit_misaligned));
                    results_seen <= results_seen + 1;
                end
                hold = draw_idle();
            end
            else if (map_valid && hold != 0)
                hold = hold - 1;
            stall_left <= hold;
            map_stall <= (hold != 0);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((extent_valid && !extent_stall) || (map_valid && !map_stall)
                || (psel && penable))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, quiet);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: 4 MiB objects, 64 KiB unit, one object per stripe
        layouts = 1;
        queue_extent('0, '0);
        queue_extent('0, 63'd1);
        queue_extent(MAX63, MAX63);
        queue_extent(MAX63, '0);
        queue_extent(63'd65535, 63'd65537);
        queue_extent(63'd4194303, 63'd100);
        queue_extent(63'd100, 63'd80 * 63'd65536);
        queue_extent('0, MAX63);
        queue_extent(63'd7 * 63'd65536, 63'd65536);
        queue_extent(63'({32{2'b01}}), 63'({32{2'b10}}));
        queue_extent(63'({32{2'b10}}), 63'({32{2'b01}}));
        // block index wraps past 32 bits
        queue_extent((63'd65536 << 32) + 63'd5, 63'd3);
        queue_extent(63'd3, 63'd65533);

        set_layout('1, '1, '1);
        queue_extent('0, MAX63);
        queue_extent(MAX63, MAX63);
        queue_extent(63'd12345, 63'd1 << 40);

        // object smaller than the unit
        set_layout(32'd1, 32'd4096, 32'd1);
        queue_extent('0, 63'd5000);
        queue_extent(63'd8191, 63'd1);

        // zero unit and zero count
        set_layout(32'd4096, 32'd0, 32'd0);
        queue_extent(63'd77777, 63'd99999);
        queue_extent(MAX63, 63'd5);

        set_layout(32'd65536, 32'd4096, 32'd0);
        queue_extent(63'd10000, 63'd100000);

        while (items_queued < ITEM_GOAL)
        begin
            logic [31:0] unit, cnt, obj;
            case ($urandom_range(0, 7))
                0:       unit = 32'd4096;
                1:       unit = 32'd4096 * $urandom_range(1, 64);
                2:       unit = $urandom;
                3:       unit = '1;
                4:       unit = '0;
                5:       unit = 32'd65536;
                default: unit = 32'd4096 << $urandom_range(0, 8);
            endcase
            case ($urandom_range(0, 7))
                0:       cnt = '0;
                1:       cnt = 32'd1;
                2:       cnt = '1;
                3:       cnt = $urandom;
                default: cnt = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       obj = unit - 1;
                1:       obj = 32'd1;
                2:       obj = '1;
                3:       obj = $urandom;
                4:       obj = '0;
                default: obj = unit * $urandom_range(1, 64);
            endcase
            set_layout(obj, unit, cnt);
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(30, 55);
            repeat (n)
            begin
                extents_todo.push_back(make_extent());
                items_queued++;
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("mapped %0d extents under %0d register settings", results_seen, layouts);
        $display("%0d extents with a misaligned unit, %0d of zero length",
                 misaligned_seen, zero_len_seen);
        if (mismatches == 0 && maps_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
